// ----- hdl/bfm_pkg.sv -----
// ----------------------------------------------------------------------------
// bfm_pkg - shared types and constants of the 3x3 box mean filter
// Pixel type, coordinate widths, neighborhood size codes and the
// reciprocal constants used to divide a window sum by its pixel count.
// ----------------------------------------------------------------------------
package bfm_pkg;

   localparam int MAX_SIDE     = 1024;
   localparam int CHANNEL_BITS = 16;
   localparam int COORD_W      = $clog2(MAX_SIDE);
   localparam int SIZE_W       = 11;
   // nine channel values summed
   localparam int SUM_W        = CHANNEL_BITS + 4;
   // reciprocal multiply: q = (sum * RECIP) >> RECIP_SHIFT
   localparam int RECIP_W      = 22;
   localparam int RECIP_SHIFT  = 23;
   localparam int PROD_W       = SUM_W + RECIP_W;

   localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(2097152);
   localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(1398102);
   localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(932068);

   // pixel count of the in-image neighborhood
   localparam logic [1:0] CNT_4 = 2'd0;
   localparam logic [1:0] CNT_6 = 2'd1;
   localparam logic [1:0] CNT_9 = 2'd2;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pixel_type;

   function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] cnt);
      logic [RECIP_W-1:0] m;
      unique case (cnt)
         CNT_4:   m = RECIP_4;
         CNT_6:   m = RECIP_6;
         CNT_9:   m = RECIP_9;
         default: m = RECIP_9;
      endcase
      return m;
   endfunction

endpackage

// ----- hdl/box_filter_3x3_edge_mean_top.sv -----
// Path: input register, window, sum register and output register, in that order.
// Throughput: one item per cycle unless the output stalls; an item with more than
// one result holds the issue stage until all are issued (up to 4 on the last pixel).
// Line buffers are single memories per row parity, one read and write per item.
// Reset (synchronous): position (0,0), window cleared, image side 1024,
// all stages empty; line buffers are not cleared.
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_mean_top - 3x3 box mean filter over a raster stream
// Input register and line read, window update, neighborhood sum, divide by
// reciprocal multiply, output register. Each item may release up to four
// results, issued one per cycle in raster order unless the output stalls.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_mean_top (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_en,
   input  logic [bfm_pkg::SIZE_W-1:0]          csr_write_data,
   // input items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bfm_pkg::CHANNEL_BITS-1:0]    req_in_red,
   input  logic [bfm_pkg::CHANNEL_BITS-1:0]    req_in_green,
   input  logic [bfm_pkg::CHANNEL_BITS-1:0]    req_in_blue,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bfm_pkg::CHANNEL_BITS-1:0]    rsp_out_red,
   output logic [bfm_pkg::CHANNEL_BITS-1:0]    rsp_out_green,
   output logic [bfm_pkg::CHANNEL_BITS-1:0]    rsp_out_blue,
   output logic [bfm_pkg::COORD_W-1:0]         rsp_out_row,
   output logic [bfm_pkg::COORD_W-1:0]         rsp_out_col,
   output logic                                rsp_run_last,
   output logic                                rsp_frame_done
);

   localparam int CW = bfm_pkg::COORD_W;
   localparam int SW = bfm_pkg::SUM_W;

   // ------------------------------------------------------------------------
   // declarations
   // ------------------------------------------------------------------------
   logic [CW-1:0]       side_last_ff;
   logic [CW-1:0]       in_row_ff;
   logic [CW-1:0]       in_col_ff;
   logic                req_take;

   logic                s0_valid_ff;
   bfm_pkg::pixel_type  s0_pix_ff;
   logic [CW-1:0]       s0_row_ff;
   logic [CW-1:0]       s0_col_ff;
   bfm_pkg::pixel_type  line_even;
   bfm_pkg::pixel_type  line_odd;
   bfm_pkg::pixel_type  req_pix;

   bfm_pkg::pixel_type  win_ff [3][3];
   logic [CW-1:0]       s1_row_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [3:0]          s1_pend_ff;
   logic [3:0]          pend_in;
   logic [3:0]          load_pend;
   logic [3:0]          issue_bit;
   logic                issue;
   logic                s1_take;

   logic                row_sel;
   logic                col_sel;
   logic [CW-1:0]       orow;
   logic [CW-1:0]       ocol;
   logic [2:0]          row_ok;
   logic [2:0]          col_ok;
   logic [SW-1:0]       sum_red;
   logic [SW-1:0]       sum_green;
   logic [SW-1:0]       sum_blue;
   logic [1:0]          cnt_code;

   logic                s2_valid_ff;
   logic [SW-1:0]       s2_red_ff;
   logic [SW-1:0]       s2_green_ff;
   logic [SW-1:0]       s2_blue_ff;
   logic [1:0]          s2_cnt_ff;
   logic [CW-1:0]       s2_row_ff;
   logic [CW-1:0]       s2_col_ff;
   logic                s2_last_ff;
   logic                s2_done_ff;
   logic                s2_free;

   logic                rsp_load;
   logic                rsp_valid_ff;
   logic [bfm_pkg::CHANNEL_BITS-1:0] rsp_red_ff;
   logic [bfm_pkg::CHANNEL_BITS-1:0] rsp_green_ff;
   logic [bfm_pkg::CHANNEL_BITS-1:0] rsp_blue_ff;
   logic [CW-1:0]       rsp_row_ff;
   logic [CW-1:0]       rsp_col_ff;
   logic                rsp_last_ff;
   logic                rsp_done_ff;
   logic [bfm_pkg::RECIP_W-1:0] recip;
   logic [bfm_pkg::PROD_W-1:0]  prod_red;
   logic [bfm_pkg::PROD_W-1:0]  prod_green;
   logic [bfm_pkg::PROD_W-1:0]  prod_blue;

   // ------------------------------------------------------------------------
   // flow control, back to front
   // ------------------------------------------------------------------------
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || rsp_load;
   assign issue     = (s1_pend_ff != 4'd0) && s2_free;
   assign issue_bit = s1_pend_ff & (~s1_pend_ff + 4'd1);
   assign pend_in   = s1_pend_ff & ~issue_bit;
   assign s1_take   = s0_valid_ff && ((s1_pend_ff == 4'd0) || (issue && pend_in == 4'd0));
   assign req_ready = !s0_valid_ff || s1_take;
   assign req_take  = req_valid && req_ready;

   // ------------------------------------------------------------------------
   // image side and raster position
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         side_last_ff <= CW'(bfm_pkg::MAX_SIDE - 1);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
      end else if (csr_write_en) begin
         if (csr_write_data < bfm_pkg::SIZE_W'(2)) begin
            side_last_ff <= CW'(1);
         end else if (csr_write_data > bfm_pkg::SIZE_W'(bfm_pkg::MAX_SIDE)) begin
            side_last_ff <= CW'(bfm_pkg::MAX_SIDE - 1);
         end else begin
            side_last_ff <= CW'(csr_write_data - bfm_pkg::SIZE_W'(1));
         end
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else if (req_take) begin
         if (in_col_ff == side_last_ff) begin
            in_col_ff <= '0;
            in_row_ff <= (in_row_ff == side_last_ff) ? '0 : in_row_ff + CW'(1);
         end else begin
            in_col_ff <= in_col_ff + CW'(1);
         end
      end
   end

   // ------------------------------------------------------------------------
   // input register and line buffer read
   // ------------------------------------------------------------------------
   assign req_pix = '{red: req_in_red, green: req_in_green, blue: req_in_blue};

   bfm_line_buf u_line_buf (
      .clock   (clock),
      .en      (req_take),
      .wr_odd  (in_row_ff[0]),
      .addr    (in_col_ff),
      .wdata   (req_pix),
      .rd_even (line_even),
      .rd_odd  (line_odd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_take) begin
         s0_valid_ff <= 1'b1;
      end else if (s1_take) begin
         s0_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_pix_ff <= req_pix;
         s0_row_ff <= in_row_ff;
         s0_col_ff <= in_col_ff;
      end
   end

   // ------------------------------------------------------------------------
   // window update and pending results of the item
   // ------------------------------------------------------------------------
   // bit 0: (r-1,c-1)  bit 1: (r-1,c)  bit 2: (r,c-1)  bit 3: (r,c)
   always_comb begin
      load_pend = 4'd0;
      if (s0_row_ff != '0) begin
         load_pend[0] = (s0_col_ff != '0);
         load_pend[1] = (s0_col_ff == side_last_ff);
      end
      if (s0_row_ff == side_last_ff) begin
         load_pend[2] = (s0_col_ff != '0);
         load_pend[3] = (s0_col_ff == side_last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write_en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_take) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         // top row is the same parity as the current row, middle the other
         win_ff[0][2] <= s0_row_ff[0] ? line_odd : line_even;
         win_ff[1][2] <= s0_row_ff[0] ? line_even : line_odd;
         win_ff[2][2] <= s0_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pend_ff <= 4'd0;
      end else if (s1_take) begin
         s1_pend_ff <= load_pend;
      end else if (issue) begin
         s1_pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_row_ff <= s0_row_ff;
         s1_col_ff <= s0_col_ff;
      end
   end

   // ------------------------------------------------------------------------
   // neighborhood sum of the result being issued
   // ------------------------------------------------------------------------
   assign row_sel = issue_bit[2] | issue_bit[3];
   assign col_sel = issue_bit[1] | issue_bit[3];
   assign orow    = s1_row_ff - CW'(1) + CW'(row_sel);
   assign ocol    = s1_col_ff - CW'(1) + CW'(col_sel);
   assign row_ok  = {orow != side_last_ff, 1'b1, orow != '0};
   assign col_ok  = {ocol != side_last_ff, 1'b1, ocol != '0};

   always_comb begin
      sum_red   = '0;
      sum_green = '0;
      sum_blue  = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (row_ok[i] && col_ok[j]) begin
               // out-of-window cells are always out of the image
               if (row_sel) begin
                  if (i < 2) begin
                     if (col_sel) begin
                        if (j < 2) begin
                           sum_red   = sum_red   + SW'(win_ff[i+1][j+1].red);
                           sum_green = sum_green + SW'(win_ff[i+1][j+1].green);
                           sum_blue  = sum_blue  + SW'(win_ff[i+1][j+1].blue);
                        end
                     end else begin
                        sum_red   = sum_red   + SW'(win_ff[i+1][j].red);
                        sum_green = sum_green + SW'(win_ff[i+1][j].green);
                        sum_blue  = sum_blue  + SW'(win_ff[i+1][j].blue);
                     end
                  end
               end else begin
                  if (col_sel) begin
                     if (j < 2) begin
                        sum_red   = sum_red   + SW'(win_ff[i][j+1].red);
                        sum_green = sum_green + SW'(win_ff[i][j+1].green);
                        sum_blue  = sum_blue  + SW'(win_ff[i][j+1].blue);
                     end
                  end else begin
                     sum_red   = sum_red   + SW'(win_ff[i][j].red);
                     sum_green = sum_green + SW'(win_ff[i][j].green);
                     sum_blue  = sum_blue  + SW'(win_ff[i][j].blue);
                  end
               end
            end
         end
      end
   end

   // 2x2, 2x3 / 3x2 or 3x3 pixels
   always_comb begin
      priority if (row_ok[0] && row_ok[2] && col_ok[0] && col_ok[2]) begin
         cnt_code = bfm_pkg::CNT_9;
      end else if ((row_ok[0] && row_ok[2]) || (col_ok[0] && col_ok[2])) begin
         cnt_code = bfm_pkg::CNT_6;
      end else begin
         cnt_code = bfm_pkg::CNT_4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s2_red_ff   <= sum_red;
         s2_green_ff <= sum_green;
         s2_blue_ff  <= sum_blue;
         s2_cnt_ff   <= cnt_code;
         s2_row_ff   <= orow;
         s2_col_ff   <= ocol;
         s2_last_ff  <= (pend_in == 4'd0);
         s2_done_ff  <= (orow == side_last_ff) && (ocol == side_last_ff);
      end
   end

   // ------------------------------------------------------------------------
   // divide by pixel count and output register
   // ------------------------------------------------------------------------
   assign recip      = bfm_pkg::recip_of(s2_cnt_ff);
   assign prod_red   = bfm_pkg::PROD_W'(s2_red_ff)   * bfm_pkg::PROD_W'(recip);
   assign prod_green = bfm_pkg::PROD_W'(s2_green_ff) * bfm_pkg::PROD_W'(recip);
   assign prod_blue  = bfm_pkg::PROD_W'(s2_blue_ff)  * bfm_pkg::PROD_W'(recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && s2_valid_ff) begin
         rsp_red_ff   <= prod_red[bfm_pkg::RECIP_SHIFT +: bfm_pkg::CHANNEL_BITS];
         rsp_green_ff <= prod_green[bfm_pkg::RECIP_SHIFT +: bfm_pkg::CHANNEL_BITS];
         rsp_blue_ff  <= prod_blue[bfm_pkg::RECIP_SHIFT +: bfm_pkg::CHANNEL_BITS];
         rsp_row_ff   <= s2_row_ff;
         rsp_col_ff   <= s2_col_ff;
         rsp_last_ff  <= s2_last_ff;
         rsp_done_ff  <= s2_done_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_red_ff;
   assign rsp_out_green  = rsp_green_ff;
   assign rsp_out_blue   = rsp_blue_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_frame_done = rsp_done_ff;

endmodule

// ----- hdl/bfm_line_buf.sv -----
// ----------------------------------------------------------------------------
// bfm_line_buf - two line buffers of the box mean filter
// One buffer per row parity. Both are read at the same column, and the
// buffer of the current row parity is written there; reads return old data.
// ----------------------------------------------------------------------------
module bfm_line_buf (
   input  logic                            clock,
   input  logic                            en,
   input  logic                            wr_odd,
   input  logic [bfm_pkg::COORD_W-1:0]     addr,
   input  bfm_pkg::pixel_type              wdata,
   output bfm_pkg::pixel_type              rd_even,
   output bfm_pkg::pixel_type              rd_odd
);

   bfm_pkg::pixel_type mem_even [bfm_pkg::MAX_SIDE];
   bfm_pkg::pixel_type mem_odd  [bfm_pkg::MAX_SIDE];
   bfm_pkg::pixel_type rd_even_ff;
   bfm_pkg::pixel_type rd_odd_ff;

   // read-before-write on the accepted column
   always_ff @(posedge clock) begin
      if (en) begin
         rd_even_ff <= mem_even[addr];
         rd_odd_ff  <= mem_odd[addr];
         if (wr_odd) begin
            mem_odd[addr] <= wdata;
         end else begin
            mem_even[addr] <= wdata;
         end
      end
   end

   assign rd_even = rd_even_ff;
   assign rd_odd  = rd_odd_ff;

endmodule

// ----- tb/box_filter_3x3_edge_mean_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_mean_top_tb - self-checking bench of the 3x3 box filter
// Streams pixel items through the filter under several side settings and
// idle patterns. A local model of line buffers and window predicts every
// filtered pixel, and each result item is checked against the oldest one.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_mean_top_tb;

   localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
   localparam int SETTLE_TICKS = 10;    // block latency plus margin
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int NUM_PLAN     = 30;

   typedef enum logic {ROW_PIXEL, ROW_SIDE} row_kind_type;

   // one line of the directed plan
   typedef struct packed {
      row_kind_type                     kind;
      logic [bfm_pkg::SIZE_W-1:0]       side;
      bfm_pkg::pixel_type               px;
      logic                             typed;     // expectation given by hand
      logic [2:0]                       n_res;
      logic [bfm_pkg::CHANNEL_BITS-1:0] mean;
   } plan_row_type;

   typedef struct packed {
      logic [bfm_pkg::CHANNEL_BITS-1:0] red;
      logic [bfm_pkg::CHANNEL_BITS-1:0] green;
      logic [bfm_pkg::CHANNEL_BITS-1:0] blue;
      logic [bfm_pkg::COORD_W-1:0]      row;
      logic [bfm_pkg::COORD_W-1:0]      col;
      logic                             run_last;
      logic                             frame_done;
   } filt_result_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_write_en;
   logic [bfm_pkg::SIZE_W-1:0]       csr_write_data;
   logic                             req_valid;
   logic                             req_ready;
   logic [bfm_pkg::CHANNEL_BITS-1:0] req_in_red;
   logic [bfm_pkg::CHANNEL_BITS-1:0] req_in_green;
   logic [bfm_pkg::CHANNEL_BITS-1:0] req_in_blue;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [bfm_pkg::CHANNEL_BITS-1:0] rsp_out_red;
   logic [bfm_pkg::CHANNEL_BITS-1:0] rsp_out_green;
   logic [bfm_pkg::CHANNEL_BITS-1:0] rsp_out_blue;
   logic [bfm_pkg::COORD_W-1:0]      rsp_out_row;
   logic [bfm_pkg::COORD_W-1:0]      rsp_out_col;
   logic                             rsp_run_last;
   logic                             rsp_frame_done;

   box_filter_3x3_edge_mean_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   bfm_pkg::pixel_type         line_mem [2*bfm_pkg::MAX_SIDE];
   bfm_pkg::pixel_type         win [3][3];
   int unsigned                pos_row;
   int unsigned                pos_col;
   logic [bfm_pkg::SIZE_W-1:0] side_reg;

   filt_result_type expected_means [$];
   filt_result_type head_res;
   int              error_count = 0;
   int              quiet_cycles = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   int              hold_left = 0;
   logic            hold_req = 1'b0;
   logic            hold_done = 1'b0;

   // directed plan: row 0 after reset, tiny frames at the extremes,
   // out-of-range sides, and a side rewrite in the middle of a frame
   plan_row_type step_plan [NUM_PLAN] = '{
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'hffff, 16'hffff}, 1'b1, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h0000, 16'h0000, 16'h0000}, 1'b1, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'haaaa, 16'h5555, 16'haaaa}, 1'b1, 3'd0, 16'h0000},
      '{ROW_SIDE,  11'd2,    {16'h0000, 16'h0000, 16'h0000}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'hffff, 16'hffff}, 1'b1, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'hffff, 16'hffff}, 1'b1, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'hffff, 16'hffff}, 1'b1, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'hffff, 16'hffff}, 1'b1, 3'd4, 16'hffff},
      '{ROW_PIXEL, 11'd0,    {16'h0000, 16'h0000, 16'h0000}, 1'b1, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h0000, 16'h0000, 16'h0000}, 1'b1, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h0000, 16'h0000, 16'h0000}, 1'b1, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h0000, 16'h0000, 16'h0000}, 1'b1, 3'd4, 16'h0000},
      '{ROW_SIDE,  11'd0,    {16'h0000, 16'h0000, 16'h0000}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h0001, 16'h0002, 16'h0003}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hfffe, 16'h8000, 16'h7fff}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h0010, 16'h0100, 16'h1000}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'h0000, 16'h5555}, 1'b0, 3'd0, 16'h0000},
      '{ROW_SIDE,  11'd1,    {16'h0000, 16'h0000, 16'h0000}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h1234, 16'h5678, 16'h9abc}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'hffff, 16'hffff}, 1'b0, 3'd0, 16'h0000},
      '{ROW_SIDE,  11'd3,    {16'h0000, 16'h0000, 16'h0000}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'h0000, 16'h8001}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h0000, 16'hffff, 16'h7ffe}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'hffff, 16'hffff}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h0003, 16'h0005, 16'h0007}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hc3c3, 16'h3c3c, 16'h0f0f}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'hffff, 16'h0000}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h0000, 16'h0001, 16'hfffe}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'h8000, 16'h8000, 16'h8000}, 1'b0, 3'd0, 16'h0000},
      '{ROW_PIXEL, 11'd0,    {16'hffff, 16'hfffe, 16'hfffd}, 1'b0, 3'd0, 16'h0000}
   };

   function automatic void log_failure(input string what);
      error_count++;
      if (error_count <= 10) $display("%s", what);
   endfunction

   // side in effect, clamped to the supported range
   function automatic int unsigned side_in_use();
      int unsigned n;
      n = side_reg;
      if (n < 2) n = 2;
      if (n > bfm_pkg::MAX_SIDE) n = bfm_pkg::MAX_SIDE;
      return n;
   endfunction

   function automatic void clear_window();
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = '0;
   endfunction

   // mean over the in-image neighborhood of (orow, ocol); window covers
   // rows r-2..r and columns c-2..c of the current position
   function automatic filt_result_type window_mean(input int unsigned n, r, c, orow,
                                                   ocol);
      int unsigned     rlo, rhi, clo, chi, rr, cc, wr, wc, count;
      int unsigned     sum_r, sum_g, sum_b;
      filt_result_type res;
      rlo = (orow == 0) ? 0 : orow - 1;
      rhi = (orow + 1 >= n) ? n - 1 : orow + 1;
      clo = (ocol == 0) ? 0 : ocol - 1;
      chi = (ocol + 1 >= n) ? n - 1 : ocol + 1;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      count = 0;
      for (rr = rlo; rr <= rhi; rr++) begin
         for (cc = clo; cc <= chi; cc++) begin
            wr = (rr + 2 - r) & 3;
            wc = (cc + 2 - c) & 3;
            if (wr <= 2 && wc <= 2) begin
               sum_r += win[wr][wc].red;
               sum_g += win[wr][wc].green;
               sum_b += win[wr][wc].blue;
               count++;
            end
         end
      end
      if (count == 0) count = 1;
      res.red        = bfm_pkg::CHANNEL_BITS'(sum_r / count);
      res.green      = bfm_pkg::CHANNEL_BITS'(sum_g / count);
      res.blue       = bfm_pkg::CHANNEL_BITS'(sum_b / count);
      res.row        = bfm_pkg::COORD_W'(orow);
      res.col        = bfm_pkg::COORD_W'(ocol);
      res.run_last   = 1'b0;
      res.frame_done = (orow == n - 1 && ocol == n - 1);
      return res;
   endfunction

   // advance the model by one pixel and queue the filtered pixels it releases
   function automatic void filter_step(input bfm_pkg::pixel_type px, input logic typed,
                                       input int typed_count,
                                       input logic [bfm_pkg::CHANNEL_BITS-1:0] typed_mean);
      int unsigned        n, r, c;
      int                 cnt;
      bfm_pkg::pixel_type top, mid;
      filt_result_type    outs [4];
      n = side_in_use();
      r = pos_row;
      c = pos_col;
      if (r >= n || c >= n) begin
         r = 0;
         c = 0;
      end
      top = '0;
      mid = '0;
      if (r >= 2) top = line_mem[(r & 1) * bfm_pkg::MAX_SIDE + c];
      if (r >= 1) mid = line_mem[((r + 1) & 1) * bfm_pkg::MAX_SIDE + c];
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      line_mem[(r & 1) * bfm_pkg::MAX_SIDE + c] = px;

      cnt = 0;
      if (r >= 1) begin
         if (c >= 1) begin
            outs[cnt] = window_mean(n, r, c, r - 1, c - 1);
            cnt++;
         end
         if (c == n - 1) begin
            outs[cnt] = window_mean(n, r, c, r - 1, c);
            cnt++;
         end
      end
      if (r == n - 1) begin
         if (c >= 1) begin
            outs[cnt] = window_mean(n, r, c, r, c - 1);
            cnt++;
         end
         if (c == n - 1) begin
            outs[cnt] = window_mean(n, r, c, r, c);
            cnt++;
         end
      end
      if (cnt > 0) outs[cnt-1].run_last = 1'b1;
      if (typed && cnt != typed_count)
         log_failure($sformatf("plan row at (%0d,%0d): %0d results listed, %0d released",
                               r, c, typed_count, cnt));
      for (int k = 0; k < cnt; k++) begin
         if (typed) begin
            outs[k].red   = typed_mean;
            outs[k].green = typed_mean;
            outs[k].blue  = typed_mean;
         end
         expected_means.push_back(outs[k]);
      end

      // raster advance with wrap at end of frame
      if (c + 1 >= n) begin
         c = 0;
         r = (r + 1 >= n) ? 0 : r + 1;
      end else begin
         c++;
      end
      pos_row = r;
      pos_col = c;
   endfunction

   function automatic bfm_pkg::pixel_type rand_pixel();
      bfm_pkg::pixel_type px;
      int unsigned        pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         px = '1;
      end else if (pick < 20) begin
         px = '0;
      end else begin
         px.red   = bfm_pkg::CHANNEL_BITS'($urandom());
         px.green = bfm_pkg::CHANNEL_BITS'($urandom());
         px.blue  = bfm_pkg::CHANNEL_BITS'($urandom());
      end
      return px;
   endfunction

   // offer one pixel item, hold it until accepted, then predict
   task automatic push_pixel(input bfm_pkg::pixel_type px, input logic typed,
                             input int typed_count,
                             input logic [bfm_pkg::CHANNEL_BITS-1:0] typed_mean);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_red   <= px.red;
      req_in_green <= px.green;
      req_in_blue  <= px.blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      filter_step(px, typed, typed_count, typed_mean);
   endtask

   task automatic stream_random(input int count);
      for (int i = 0; i < count; i++) push_pixel(rand_pixel(), 1'b0, 0, '0);
   endtask

   // stop offering, wait for every expected item, then let the pipe settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // side write; call only with the block idle
   task automatic write_side(input logic [bfm_pkg::SIZE_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      side_reg = value;
      pos_row  = 0;
      pos_col  = 0;
      clear_window();
   endtask

   // mostly whole frames of small sides, some cut short and rewritten
   task automatic random_frames(input int goal);
      int          sent;
      int          len;
      int          pause_at;
      int unsigned pick;
      int unsigned n;
      sent = 0;
      while (sent < goal) begin
         if (sent == 0 || $urandom_range(99) < 60) begin
            wait_drained();
            pick = $urandom_range(99);
            if (pick < 85) write_side(bfm_pkg::SIZE_W'($urandom_range(2, 8)));
            else if (pick < 93) write_side(bfm_pkg::SIZE_W'($urandom_range(0, 1)));
            else write_side(bfm_pkg::SIZE_W'($urandom_range(9, 12)));
         end
         n = side_in_use();
         len = ($urandom_range(99) < 80) ? n * n : $urandom_range(1, n * n - 1);
         pause_at = ($urandom_range(99) < 15) ? $urandom_range(0, len - 1) : -1;
         for (int i = 0; i < len; i++) begin
            if (i == pause_at) wait_drained();
            push_pixel(rand_pixel(), 1'b0, 0, '0);
         end
         sent += len;
      end
   endtask

   // result side: check each accepted item, then choose ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_means.size() == 0) begin
            log_failure($sformatf("unexpected result row %0d col %0d", rsp_out_row,
                                  rsp_out_col));
         end else begin
            head_res = expected_means.pop_front();
            if (rsp_out_red !== head_res.red || rsp_out_green !== head_res.green ||
                rsp_out_blue !== head_res.blue || rsp_out_row !== head_res.row ||
                rsp_out_col !== head_res.col || rsp_run_last !== head_res.run_last ||
                rsp_frame_done !== head_res.frame_done)
               log_failure($sformatf(
                  "mismatch exp rgb %h %h %h r%0d c%0d l%b d%b got rgb %h %h %h r%0d c%0d l%b d%b",
                  head_res.red, head_res.green, head_res.blue, head_res.row, head_res.col,
                  head_res.run_last, head_res.frame_done, rsp_out_red, rsp_out_green,
                  rsp_out_blue, rsp_out_row, rsp_out_col, rsp_run_last, rsp_frame_done));
         end
      end
      if (hold_req && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int send_modes  [4];
      int stall_modes [4];
      send_modes  = '{0, 65, 0, 25};
      stall_modes = '{0, 0, 65, 25};
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_valid      = 1'b0;
      req_in_red     = '0;
      req_in_green   = '0;
      req_in_blue    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // model after reset
      for (int i = 0; i < 2 * bfm_pkg::MAX_SIDE; i++) line_mem[i] = '0;
      clear_window();
      pos_row  = 0;
      pos_col  = 0;
      side_reg = bfm_pkg::SIZE_W'(bfm_pkg::MAX_SIDE);

      // directed plan
      for (int i = 0; i < NUM_PLAN; i++) begin
         if (step_plan[i].kind == ROW_SIDE) begin
            wait_drained();
            write_side(step_plan[i].side);
         end else begin
            push_pixel(step_plan[i].px, step_plan[i].typed, step_plan[i].n_res,
                       step_plan[i].mean);
         end
      end

      // largest side and an oversized write: row 0 only, nothing released
      send_idle_pct = 25;
      stall_pct     = 25;
      wait_drained();
      write_side(bfm_pkg::SIZE_W'(bfm_pkg::MAX_SIDE));
      stream_random(12);
      wait_drained();
      write_side('1);
      stream_random(12);

      for (int m = 0; m < 4; m++) begin
         send_idle_pct = send_modes[m];
         stall_pct     = stall_modes[m];
         random_frames(20);
         if (m == 0) begin
            // receiver holds off while the sender keeps pushing; then a
            // sender pause mid-stream until all results are in
            wait_drained();
            write_side(bfm_pkg::SIZE_W'(4));
            hold_req <= 1'b1;
            stream_random(24);
            wait_drained();
            stream_random(24);
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/bfm_pkg.sv
hdl/bfm_line_buf.sv
hdl/box_filter_3x3_edge_mean_top.sv
tb/box_filter_3x3_edge_mean_top_tb.sv
